// File: rtl/vdl2c_pkg.sv
package vdl2c_pkg;

  localparam int LANES   = 4;
  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int ACC_W   = 42;
  localparam int HALF_W  = ACC_W / 2;
  localparam int FRAC_W  = 28;
  localparam int Q_W     = 41;
  localparam int CNT_W   = 3;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [ACC_W-1:0] ONE_Q = ACC_W'(1) << FRAC_W;
  localparam logic [ACC_W-1:0] TWO_Q = ACC_W'(1) << (FRAC_W + 1);

  // register byte addresses
  localparam logic [PADDR_W-1:0] ADDR_METRIC_MODE = 3'd0;

  localparam logic MODE_L2     = 1'b0;
  localparam logic MODE_COSINE = 1'b1;

  typedef struct packed {
    logic signed [ELEM_W-1:0] left_lane0;
    logic signed [ELEM_W-1:0] left_lane1;
    logic signed [ELEM_W-1:0] left_lane2;
    logic signed [ELEM_W-1:0] left_lane3;
    logic signed [ELEM_W-1:0] right_lane0;
    logic signed [ELEM_W-1:0] right_lane1;
    logic signed [ELEM_W-1:0] right_lane2;
    logic signed [ELEM_W-1:0] right_lane3;
    logic [CNT_W-1:0]         lanes_valid;
    logic                     last_group;
  } in_item_t;

  typedef struct packed {
    logic [ACC_W-1:0] distance;
    logic             zero_norm;
    logic             saturated;
  } out_item_t;

  typedef struct packed {
    logic [PROD_W-1:0]        sq_diff;
    logic signed [PROD_W-1:0] dot;
    logic [PROD_W-1:0]        sq_left;
    logic [PROD_W-1:0]        sq_right;
  } lane_prod_t;

  typedef struct packed {
    logic [ACC_W-1:0]        diff;
    logic signed [ACC_W-1:0] dot;
    logic [ACC_W-1:0]        lnorm;
    logic [ACC_W-1:0]        rnorm;
    logic                    sat;
  } acc_t;

  typedef enum logic [2:0] {
    ST_RUN = 3'b001,
    ST_FIN = 3'b010,
    ST_COS = 3'b100
  } top_state_t;

  typedef enum logic [4:0] {
    CS_IDLE = 5'b00001,
    CS_MUL  = 5'b00010,
    CS_SQRT = 5'b00100,
    CS_DIV  = 5'b01000,
    CS_DONE = 5'b10000
  } cos_state_t;

endpackage

// File: rtl/vdl2c_lane.sv
module vdl2c_lane (
  input  logic                               clk,
  input  logic                               en,
  input  logic                               act,
  input  logic signed [vdl2c_pkg::ELEM_W-1:0] left,
  input  logic signed [vdl2c_pkg::ELEM_W-1:0] right,
  output vdl2c_pkg::lane_prod_t              prod_r
);

  logic signed [vdl2c_pkg::ELEM_W:0]  d;
  logic [vdl2c_pkg::ELEM_W:0]         ad_w;
  logic [vdl2c_pkg::ELEM_W-1:0]       ad;
  logic [vdl2c_pkg::ELEM_W-1:0]       al;
  logic [vdl2c_pkg::ELEM_W-1:0]       ar;
  vdl2c_pkg::lane_prod_t              prod_nxt;

  always_comb begin
    d    = {left[vdl2c_pkg::ELEM_W-1], left} - {right[vdl2c_pkg::ELEM_W-1], right};
    ad_w = d[vdl2c_pkg::ELEM_W] ? (~d + 1'b1) : d;
    ad   = ad_w[vdl2c_pkg::ELEM_W-1:0];
    al   = left[vdl2c_pkg::ELEM_W-1] ? (~left + 1'b1) : left;
    ar   = right[vdl2c_pkg::ELEM_W-1] ? (~right + 1'b1) : right;
    prod_nxt.sq_diff  = ad * ad;
    prod_nxt.dot      = left * right;
    prod_nxt.sq_left  = al * al;
    prod_nxt.sq_right = ar * ar;
    // idle lanes contribute nothing
    if (!act) begin
      prod_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// File: rtl/vdl2c_merge.sv
module vdl2c_merge (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  clr,
  input  vdl2c_pkg::lane_prod_t prod [vdl2c_pkg::LANES],
  output vdl2c_pkg::acc_t       acc_r
);

  localparam logic [vdl2c_pkg::ACC_W+1:0] UMAX_W = {2'b00, {vdl2c_pkg::ACC_W{1'b1}}};

  vdl2c_pkg::acc_t acc_nxt;
  vdl2c_pkg::acc_t acc_upd;

  always_comb begin
    logic [vdl2c_pkg::ACC_W+1:0]        sd;
    logic [vdl2c_pkg::ACC_W+1:0]        sl;
    logic [vdl2c_pkg::ACC_W+1:0]        sr;
    logic signed [vdl2c_pkg::ACC_W:0]   s;
    logic signed [vdl2c_pkg::ACC_W-1:0] dacc;
    logic                               sat;
    sat  = acc_r.sat;
    sd   = {2'b00, acc_r.diff};
    sl   = {2'b00, acc_r.lnorm};
    sr   = {2'b00, acc_r.rnorm};
    dacc = acc_r.dot;
    // unsigned sums only grow: clipping the total equals clipping each add
    for (int i = 0; i < vdl2c_pkg::LANES; i++) begin
      sd = sd + (vdl2c_pkg::ACC_W + 2)'(prod[i].sq_diff);
      sl = sl + (vdl2c_pkg::ACC_W + 2)'(prod[i].sq_left);
      sr = sr + (vdl2c_pkg::ACC_W + 2)'(prod[i].sq_right);
    end
    // signed dot clips in lane order
    for (int i = 0; i < vdl2c_pkg::LANES; i++) begin
      s = {dacc[vdl2c_pkg::ACC_W-1], dacc} + (vdl2c_pkg::ACC_W + 1)'(prod[i].dot);
      if (s[vdl2c_pkg::ACC_W] != s[vdl2c_pkg::ACC_W-1]) begin
        sat  = 1'b1;
        dacc = s[vdl2c_pkg::ACC_W] ? {1'b1, {(vdl2c_pkg::ACC_W-1){1'b0}}}
                                   : {1'b0, {(vdl2c_pkg::ACC_W-1){1'b1}}};
      end else begin
        dacc = s[vdl2c_pkg::ACC_W-1:0];
      end
    end
    acc_upd.dot = dacc;
    if (sd > UMAX_W) begin
      sat = 1'b1;
      acc_upd.diff = {vdl2c_pkg::ACC_W{1'b1}};
    end else begin
      acc_upd.diff = sd[vdl2c_pkg::ACC_W-1:0];
    end
    if (sl > UMAX_W) begin
      sat = 1'b1;
      acc_upd.lnorm = {vdl2c_pkg::ACC_W{1'b1}};
    end else begin
      acc_upd.lnorm = sl[vdl2c_pkg::ACC_W-1:0];
    end
    if (sr > UMAX_W) begin
      sat = 1'b1;
      acc_upd.rnorm = {vdl2c_pkg::ACC_W{1'b1}};
    end else begin
      acc_upd.rnorm = sr[vdl2c_pkg::ACC_W-1:0];
    end
    acc_upd.sat = sat;

    acc_nxt = acc_r;
    if (clr) begin
      acc_nxt = '0;
    end else if (en) begin
      acc_nxt = acc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// File: rtl/vdl2c_cos.sv
module vdl2c_cos (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               ack,
  input  logic [vdl2c_pkg::ACC_W-1:0]        lnorm,
  input  logic [vdl2c_pkg::ACC_W-1:0]        rnorm,
  input  logic signed [vdl2c_pkg::ACC_W-1:0] dot,
  output logic                               done,
  output logic [vdl2c_pkg::ACC_W-1:0]        distance
);

  localparam int PW    = 2 * vdl2c_pkg::ACC_W;
  localparam int REM_W = vdl2c_pkg::ACC_W + 3;
  localparam int NUM_W = vdl2c_pkg::ACC_W + vdl2c_pkg::FRAC_W;
  localparam int H     = vdl2c_pkg::HALF_W;
  localparam logic [6:0] MUL_LAST  = 7'd3;
  localparam logic [6:0] SQRT_LAST = 7'(vdl2c_pkg::ACC_W - 1);
  localparam logic [6:0] DIV_LAST  = 7'(NUM_W - 1);

  vdl2c_pkg::cos_state_t state_r, state_nxt;
  logic [6:0]                  cnt_r, cnt_nxt;
  logic [vdl2c_pkg::ACC_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic                        neg_r, neg_nxt;
  logic [PW-1:0]               prod_r, prod_nxt;
  logic [vdl2c_pkg::ACC_W-1:0] root_r, root_nxt;
  logic [REM_W-1:0]            rem_r, rem_nxt;
  logic [NUM_W-1:0]            num_r, num_nxt;
  logic [vdl2c_pkg::ACC_W-1:0] drem_r, drem_nxt;
  logic [vdl2c_pkg::Q_W-1:0]   q_r, q_nxt;

  always_comb begin
    logic [H-1:0]                 ah;
    logic [H-1:0]                 bh;
    logic [2*H-1:0]               pp;
    logic [REM_W-1:0]             rem2;
    logic [REM_W-1:0]             trial;
    logic [vdl2c_pkg::ACC_W:0]    dsh;
    logic [vdl2c_pkg::Q_W-1:0]    qs;
    logic [vdl2c_pkg::ACC_W-1:0]  mag;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    neg_nxt   = neg_r;
    prod_nxt  = prod_r;
    root_nxt  = root_r;
    rem_nxt   = rem_r;
    num_nxt   = num_r;
    drem_nxt  = drem_r;
    q_nxt     = q_r;
    ah    = cnt_r[0] ? a_r[2*H-1:H] : a_r[H-1:0];
    bh    = cnt_r[1] ? b_r[2*H-1:H] : b_r[H-1:0];
    pp    = ah * bh;
    rem2  = {rem_r[REM_W-3:0], prod_r[PW-1 -: 2]};
    trial = REM_W'({root_r, 2'b01});
    dsh   = {drem_r, num_r[NUM_W-1]};
    qs    = q_r[vdl2c_pkg::Q_W-1] ? q_r : {q_r[vdl2c_pkg::Q_W-2:0], 1'b0};
    mag   = dot[vdl2c_pkg::ACC_W-1] ? (~dot + 1'b1) : dot;
    case (state_r)
      vdl2c_pkg::CS_IDLE: begin
        if (start) begin
          a_nxt     = lnorm;
          b_nxt     = rnorm;
          neg_nxt   = dot[vdl2c_pkg::ACC_W-1];
          num_nxt   = {mag, {vdl2c_pkg::FRAC_W{1'b0}}};
          prod_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = vdl2c_pkg::CS_MUL;
        end
      end
      vdl2c_pkg::CS_MUL: begin
        // one 21x21 partial product per cycle
        prod_nxt = prod_r + ({{(PW-2*H){1'b0}}, pp} << (H * (int'(cnt_r[0]) + int'(cnt_r[1]))));
        cnt_nxt  = cnt_r + 7'd1;
        if (cnt_r == MUL_LAST) begin
          cnt_nxt   = '0;
          root_nxt  = '0;
          rem_nxt   = '0;
          state_nxt = vdl2c_pkg::CS_SQRT;
        end
      end
      vdl2c_pkg::CS_SQRT: begin
        // restoring square root, two radicand bits per step
        prod_nxt = {prod_r[PW-3:0], 2'b00};
        if (rem2 >= trial) begin
          rem_nxt  = rem2 - trial;
          root_nxt = {root_r[vdl2c_pkg::ACC_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem2;
          root_nxt = {root_r[vdl2c_pkg::ACC_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == SQRT_LAST) begin
          cnt_nxt   = '0;
          drem_nxt  = '0;
          q_nxt     = '0;
          state_nxt = vdl2c_pkg::CS_DIV;
        end
      end
      vdl2c_pkg::CS_DIV: begin
        // restoring division, quotient held at its cap once reached
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
        q_nxt   = qs;
        if (dsh >= {1'b0, root_r}) begin
          drem_nxt = vdl2c_pkg::ACC_W'(dsh - {1'b0, root_r});
          if (!qs[vdl2c_pkg::Q_W-1]) begin
            q_nxt = qs | vdl2c_pkg::Q_W'(1);
          end
        end else begin
          drem_nxt = dsh[vdl2c_pkg::ACC_W-1:0];
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = vdl2c_pkg::CS_DONE;
        end
      end
      vdl2c_pkg::CS_DONE: begin
        if (ack) begin
          state_nxt = vdl2c_pkg::CS_IDLE;
        end
      end
      default: begin
        state_nxt = vdl2c_pkg::CS_IDLE;
      end
    endcase
  end

  always_comb begin
    logic big;
    big = |q_r[vdl2c_pkg::Q_W-1:vdl2c_pkg::FRAC_W];
    if (neg_r) begin
      distance = big ? vdl2c_pkg::TWO_Q : vdl2c_pkg::ONE_Q + vdl2c_pkg::ACC_W'(q_r);
    end else begin
      distance = big ? '0 : vdl2c_pkg::ONE_Q - vdl2c_pkg::ACC_W'(q_r);
    end
  end

  assign done = (state_r == vdl2c_pkg::CS_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vdl2c_pkg::CS_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    neg_r  <= neg_nxt;
    prod_r <= prod_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
    num_r  <= num_nxt;
    drem_r <= drem_nxt;
    q_r    <= q_nxt;
  end

endmodule

// File: rtl/vector_distance_l2_cosine.sv
// Streaming distance unit. Each input transaction carries up to four signed
// Q1.14 element pairs; four lanes form and register the squared difference,
// the product and both squares, and a merge stage folds them into 42-bit
// saturating accumulators, so groups stream at one transaction per clock
// until the transaction flagged last_group closes the vector: input then
// stalls until the result is formed. Squared euclidean mode (metric_mode
// = 0) loads the squared-difference sum once the result register is free;
// cosine mode runs one shared iterative unit (4 multiply steps, 42
// square-root steps and 70 divide steps) unless a norm is zero, which
// answers 1.0 with zero_norm set. The result is unsigned Q14.28; saturated
// reports that any accumulator clipped during the vector. Accumulators
// clear after every result. The result register lets the next vector stream
// in while a result waits to be taken. Write metric_mode only while idle.
module vector_distance_l2_cosine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  vdl2c_pkg::in_item_t               in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output vdl2c_pkg::out_item_t              out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vdl2c_pkg::PADDR_W-1:0]     paddr,
  input  logic [vdl2c_pkg::PDATA_W-1:0]     pwdata,
  output logic [vdl2c_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);

  vdl2c_pkg::top_state_t state_r, state_nxt;
  logic                  mode_r;
  logic                  s1_v_r, s1_last_r;
  logic                  out_valid_r;
  vdl2c_pkg::out_item_t  out_data_r;
  logic                  sat_hold_r;
  logic                  accept;
  logic                  clr;
  logic                  cos_start, cos_done, cos_ack;
  logic [vdl2c_pkg::ACC_W-1:0] cos_dist;
  logic                  cos_path;
  logic                  load_out;
  vdl2c_pkg::out_item_t  load_data;
  vdl2c_pkg::acc_t       acc;

  logic signed [vdl2c_pkg::ELEM_W-1:0] left_a  [vdl2c_pkg::LANES];
  logic signed [vdl2c_pkg::ELEM_W-1:0] right_a [vdl2c_pkg::LANES];
  vdl2c_pkg::lane_prod_t               prod    [vdl2c_pkg::LANES];

  // Configuration port: pready is tied high, so accesses never wait.
  assign pready = 1'b1;
  assign prdata = (paddr == vdl2c_pkg::ADDR_METRIC_MODE) ?
                  vdl2c_pkg::PDATA_W'(mode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= vdl2c_pkg::MODE_L2;
    end else if (psel && penable && pwrite && pready &&
                 paddr == vdl2c_pkg::ADDR_METRIC_MODE) begin
      mode_r <= pwdata[0];
    end
  end

  // Hold input while a vector is closing.
  assign in_ready = (state_r == vdl2c_pkg::ST_RUN) && !(s1_v_r && s1_last_r);
  assign accept   = in_valid && in_ready;

  assign left_a[0]  = in_data.left_lane0;
  assign left_a[1]  = in_data.left_lane1;
  assign left_a[2]  = in_data.left_lane2;
  assign left_a[3]  = in_data.left_lane3;
  assign right_a[0] = in_data.right_lane0;
  assign right_a[1] = in_data.right_lane1;
  assign right_a[2] = in_data.right_lane2;
  assign right_a[3] = in_data.right_lane3;

  // Lane products, registered on accept.
  for (genvar g = 0; g < vdl2c_pkg::LANES; g++) begin : g_lane
    vdl2c_lane u_lane (
      .clk    (clk),
      .en     (accept),
      .act    (in_data.lanes_valid > vdl2c_pkg::CNT_W'(g)),
      .left   (left_a[g]),
      .right  (right_a[g]),
      .prod_r (prod[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s1_last_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      if (accept) begin
        s1_last_r <= in_data.last_group;
      end
    end
  end

  vdl2c_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (s1_v_r),
    .clr   (clr),
    .prod  (prod),
    .acc_r (acc)
  );

  vdl2c_cos u_cos (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cos_start),
    .ack      (cos_ack),
    .lnorm    (acc.lnorm),
    .rnorm    (acc.rnorm),
    .dot      (acc.dot),
    .done     (cos_done),
    .distance (cos_dist)
  );

  assign cos_path = (mode_r == vdl2c_pkg::MODE_COSINE) &&
                    (acc.lnorm != '0) && (acc.rnorm != '0);

  // Close the vector: direct answer, or hand off to the cosine unit.
  always_comb begin
    state_nxt = state_r;
    clr       = 1'b0;
    cos_start = 1'b0;
    cos_ack   = 1'b0;
    load_out  = 1'b0;
    load_data = '0;
    case (state_r)
      vdl2c_pkg::ST_RUN: begin
        if (s1_v_r && s1_last_r) begin
          state_nxt = vdl2c_pkg::ST_FIN;
        end
      end
      vdl2c_pkg::ST_FIN: begin
        if (cos_path) begin
          cos_start = 1'b1;
          clr       = 1'b1;
          state_nxt = vdl2c_pkg::ST_COS;
        end else if (!out_valid_r) begin
          load_out = 1'b1;
          clr      = 1'b1;
          if (mode_r == vdl2c_pkg::MODE_COSINE) begin
            load_data.distance  = vdl2c_pkg::ONE_Q;
            load_data.zero_norm = 1'b1;
          end else begin
            load_data.distance  = acc.diff;
            load_data.zero_norm = 1'b0;
          end
          load_data.saturated = acc.sat;
          state_nxt = vdl2c_pkg::ST_RUN;
        end
      end
      vdl2c_pkg::ST_COS: begin
        if (cos_done && !out_valid_r) begin
          load_out            = 1'b1;
          cos_ack             = 1'b1;
          load_data.distance  = cos_dist;
          load_data.zero_norm = 1'b0;
          load_data.saturated = sat_hold_r;
          state_nxt           = vdl2c_pkg::ST_RUN;
        end
      end
      default: begin
        state_nxt = vdl2c_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vdl2c_pkg::ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cos_start) begin
      sat_hold_r <= acc.sat;
    end
    if (load_out) begin
      out_data_r <= load_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Never take input while a vector is closing.
  a_no_accept_closing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != vdl2c_pkg::ST_RUN) |-> !in_ready)
    else $error("input accepted while closing a vector");

  // Never overwrite a waiting result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !out_valid_r)
    else $error("result register overwritten");

  // A zero norm always reports exactly 1.0.
  a_zero_norm_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.zero_norm) |-> (out_data_r.distance == vdl2c_pkg::ONE_Q))
    else $error("zero_norm without distance 1.0");

  // After the cosine unit is started, the top is in its cosine state and the unit is not yet done.
  a_cos_start: assert property (@(posedge clk) disable iff (!rst_n)
    cos_start |=> (state_r == vdl2c_pkg::ST_COS) && !cos_done)
    else $error("cosine unit start out of sequence");

endmodule

// File: tb/sv/distance_checker.sv
module distance_checker
  import vdl2c_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  input  logic                pready,
  output int                  mismatch_count,
  output int                  pending_results,
  output int                  l2_checked,
  output int                  cosine_checked,
  output int                  clipped_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ACC_W-1:0] UACC_MAX = '1;
  localparam longint SACC_MAX = (64'sd1 <<< (ACC_W - 1)) - 1;
  localparam longint SACC_MIN = -SACC_MAX - 1;
  localparam logic [127:0] QUOT_CAP = 128'd1 << 40;

  logic                    mode_q;
  logic [ACC_W-1:0]        sqdiff_acc, lnorm_acc, rnorm_acc;
  longint                  dot_acc;
  logic                    clip_seen;
  out_item_t               distance_q[$];

  function automatic logic [127:0] floor_root(logic [127:0] prod);
    logic [127:0] root, cand;
    root = '0;
    for (int b = 42; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= prod) root = cand;
    end
    return root;
  endfunction

  function automatic void add_norm(ref logic [ACC_W-1:0] acc, input longint x);
    logic [ACC_W:0] sum;
    sum = {1'b0, acc} + x[ACC_W:0];
    if (sum > {1'b0, UACC_MAX}) begin
      acc = UACC_MAX;
      clip_seen = 1'b1;
    end else begin
      acc = sum[ACC_W-1:0];
    end
  endfunction

  function automatic out_item_t close_vector();
    out_item_t res;
    logic [127:0] root, num, quot;
    longint mag;
    res = '0;
    if (mode_q == MODE_L2) begin
      res.distance = sqdiff_acc;
    end else if (lnorm_acc == 0 || rnorm_acc == 0) begin
      res.distance = ONE_Q;
      res.zero_norm = 1'b1;
    end else begin
      root = floor_root(128'(lnorm_acc) * 128'(rnorm_acc));
      mag  = dot_acc < 0 ? -dot_acc : dot_acc;
      num  = 128'(mag) << FRAC_W;
      quot = num / root;
      if (quot > QUOT_CAP) quot = QUOT_CAP;
      if (dot_acc < 0)
        res.distance = quot >= 128'(ONE_Q) ? TWO_Q : ONE_Q + quot[ACC_W-1:0];
      else
        res.distance = quot >= 128'(ONE_Q) ? '0 : ONE_Q - quot[ACC_W-1:0];
    end
    res.saturated = clip_seen;
    return res;
  endfunction

  // fold one accepted lane group into the running sums
  function automatic void accumulate(in_item_t g);
    logic signed [ELEM_W-1:0] lft[LANES], rgt[LANES];
    longint l, r, d, s;
    int n;
    lft = '{g.left_lane0, g.left_lane1, g.left_lane2, g.left_lane3};
    rgt = '{g.right_lane0, g.right_lane1, g.right_lane2, g.right_lane3};
    n = g.lanes_valid > LANES ? LANES : g.lanes_valid;
    for (int i = 0; i < n; i++) begin
      l = lft[i];
      r = rgt[i];
      d = l - r;
      add_norm(sqdiff_acc, d * d);
      s = dot_acc + l * r;
      if (s > SACC_MAX) begin s = SACC_MAX; clip_seen = 1'b1; end
      if (s < SACC_MIN) begin s = SACC_MIN; clip_seen = 1'b1; end
      dot_acc = s;
      add_norm(lnorm_acc, l * l);
      add_norm(rnorm_acc, r * r);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      mode_q = MODE_L2;
      sqdiff_acc = '0; lnorm_acc = '0; rnorm_acc = '0; dot_acc = 0; clip_seen = 1'b0;
      distance_q.delete();
      mismatch_count = 0;
      l2_checked = 0; cosine_checked = 0; clipped_checked = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_METRIC_MODE)
        mode_q = pwdata[0];
      if (in_valid && in_ready) begin
        accumulate(in_data);
        if (in_data.last_group) begin
          distance_q = {distance_q, close_vector()};
          if (mode_q == MODE_L2) l2_checked++;
          else cosine_checked++;
          sqdiff_acc = '0; lnorm_acc = '0; rnorm_acc = '0; dot_acc = 0;
          clip_seen = 1'b0;
        end
      end
      if (out_valid && out_ready) begin
        if (distance_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result distance=%0h zero_norm=%0b saturated=%0b",
                   $time, out_data.distance, out_data.zero_norm, out_data.saturated);
        end else begin
          exp_r = distance_q.pop_front();
          if (exp_r.saturated) clipped_checked++;
          if (exp_r.distance !== out_data.distance) begin
            mismatch_count++;
            $display("%0t: distance expected %0h actual %0h", $time,
                     exp_r.distance, out_data.distance);
          end
          if (exp_r.zero_norm !== out_data.zero_norm) begin
            mismatch_count++;
            $display("%0t: zero_norm expected %0b actual %0b", $time,
                     exp_r.zero_norm, out_data.zero_norm);
          end
          if (exp_r.saturated !== out_data.saturated) begin
            mismatch_count++;
            $display("%0t: saturated expected %0b actual %0b", $time,
                     exp_r.saturated, out_data.saturated);
          end
        end
      end
    end
    pending_results = distance_q.size();
  end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  import vdl2c_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // margin for a cosine closing before idle writes
  localparam int SETTLE_CYCLES = 200;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int mismatch_count, pending_results, l2_checked, cosine_checked, clipped_checked;
  int sink_hold = 0;   // long receiver hold-off requested by the stimulus
  bit quiet = 1'b0;    // no idling on either side while set
  int groups_sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  vector_distance_l2_cosine u_top (.*);

  distance_checker u_chk (.*);

  // Receiver: random stalls, mostly short with a few long, plus the hold-off.
  always @(posedge clk) begin
    int stall_left;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold--;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(5) == 0)
        stall_left = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 1);
    end
  end

  // Hold the transaction until the block takes it, then sometimes idle a while.
  task automatic push_group(in_item_t g);
    int gap;
    in_valid <= 1'b1;
    in_data  <= g;
    do @(posedge clk); while (!in_ready);
    groups_sent++;
    gap = 0;
    if (!quiet && $urandom_range(2) == 0)
      gap = ($urandom_range(11) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every result has drained and the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_results == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_METRIC_MODE;
    pwdata  <= PDATA_W'(m);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [ELEM_W-1:0] pick_elem();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return ELEM_W'($urandom_range(64)) - 16'sd32;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t make_group(int lanes, bit last);
    in_item_t g;
    g.left_lane0  = pick_elem(); g.left_lane1  = pick_elem();
    g.left_lane2  = pick_elem(); g.left_lane3  = pick_elem();
    g.right_lane0 = pick_elem(); g.right_lane1 = pick_elem();
    g.right_lane2 = pick_elem(); g.right_lane3 = pick_elem();
    g.lanes_valid = CNT_W'(lanes);
    g.last_group  = last;
    // bias some groups toward zero, aligned or opposite vectors
    case ($urandom_range(9))
      0: {g.left_lane0, g.left_lane1, g.left_lane2, g.left_lane3} = '0;
      1: {g.right_lane0, g.right_lane1, g.right_lane2, g.right_lane3} = '0;
      2: begin
        g.right_lane0 = g.left_lane0; g.right_lane1 = g.left_lane1;
        g.right_lane2 = g.left_lane2; g.right_lane3 = g.left_lane3;
      end
      3: begin
        g.right_lane0 = -g.left_lane0; g.right_lane1 = -g.left_lane1;
        g.right_lane2 = -g.left_lane2; g.right_lane3 = -g.left_lane3;
      end
      default: ;
    endcase
    return g;
  endfunction

  function automatic in_item_t fill_group(logic signed [ELEM_W-1:0] l,
                                          logic signed [ELEM_W-1:0] r,
                                          int lanes, bit last);
    in_item_t g;
    g = '{l, l, l, l, r, r, r, r, CNT_W'(lanes), last};
    return g;
  endfunction

  // One random vector pair; mostly a few groups, lane counts mostly full.
  task automatic random_vector();
    int n_groups, lanes;
    n_groups = ($urandom_range(7) == 0) ? $urandom_range(20, 6) : $urandom_range(4, 1);
    for (int i = 0; i < n_groups; i++) begin
      lanes = ($urandom_range(3) == 0) ? $urandom_range(7) : LANES;
      push_group(make_group(lanes, i == n_groups - 1));
    end
  endtask

  // Long extreme vector: with l and r far apart it clips the squared-difference accumulator.
  task automatic clipping_vector(logic signed [ELEM_W-1:0] l, logic signed [ELEM_W-1:0] r);
    for (int i = 0; i < 300; i++)
      push_group(fill_group(l, r, LANES, i == 299));
  endtask

  task automatic directed_set();
    push_group(fill_group(16'sh7fff, 16'sh8000, LANES, 1'b1));
    push_group(fill_group(16'sh8000, 16'sh8000, LANES, 1'b1));
    push_group(fill_group(16'sh4000, 16'sh4000, LANES, 1'b1));
    push_group(fill_group(16'sh4000, -16'sh4000, LANES, 1'b1));
    push_group(fill_group('0, 16'sh1234, LANES, 1'b1));
    push_group(fill_group(16'sh1234, '0, LANES, 1'b1));
    push_group(fill_group(16'sh7fff, 16'sh0001, 0, 1'b1));   // empty vector
    push_group(fill_group(16'sh0100, 16'sh0200, 7, 1'b1));   // lane count clipped
    push_group(make_group(1, 1'b0));
    push_group(make_group(2, 1'b0));
    push_group(make_group(3, 1'b0));
    push_group(make_group(5, 1'b0));
    push_group(make_group(0, 1'b1));                          // empty closing group
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass in each mode, back to back without idling.
    quiet = 1'b1;
    directed_set();
    drain();
    write_mode(MODE_COSINE);
    directed_set();
    drain();
    quiet = 1'b0;

    clipping_vector(16'sh7fff, 16'sh8000);
    drain();
    write_mode(MODE_L2);
    clipping_vector(16'sh8000, 16'sh8000);
    drain();

    // Random phases, alternating the metric between them.
    for (int ph = 0; groups_sent < 1350; ph++) begin
      write_mode(ph[0] ? MODE_L2 : MODE_COSINE);
      quiet = (ph % 4 == 3);
      if (ph == 1) begin
        // hold off the receiver so the result register fills and input stalls
        sink_hold = 400;
        for (int v = 0; v < 30; v++) random_vector();
      end else begin
        for (int v = 0; v < 25; v++) random_vector();
      end
      drain();
    end

    quiet = 1'b0;
    wait (pending_results == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d lane groups: %0d squared-euclidean and %0d cosine results,",
             groups_sent, l2_checked, cosine_checked);
    $display("%0d of them with a clipped accumulator", clipped_checked);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("vector_distance_l2_cosine verification clean");
    end else begin
      $display("vector_distance_l2_cosine verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("vector_distance_l2_cosine verification failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/vdl2c_pkg.sv
rtl/vdl2c_lane.sv
rtl/vdl2c_merge.sv
rtl/vdl2c_cos.sv
rtl/vector_distance_l2_cosine.sv
tb/sv/distance_checker.sv
tb/sv/tb_top.sv
